/* design/pfd_pkg.sv */
// shared types, constants and helper functions for the filtered-derivative pid block
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int DT_BITS = 24;
  localparam int GAIN_W = 24;
  localparam int LIMIT_W = 31;
  localparam int VALUE_W = 32;
  localparam int PROD_W = 65;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes on the config port
  localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [2:0] REG_FILTER_COEFF   = 3'd3;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd5;
  localparam logic [2:0] REG_WRAP_ENABLE    = 3'd6;

  // datapath step codes, one shared multiply per step
  localparam logic [2:0] STEP_ERR   = 3'd0;
  localparam logic [2:0] STEP_FCDT  = 3'd1;
  localparam logic [2:0] STEP_KDFC  = 3'd2;
  localparam logic [2:0] STEP_KIDT  = 3'd3;
  localparam logic [2:0] STEP_DFILT = 3'd4;
  localparam logic [2:0] STEP_DERIV = 3'd5;
  localparam logic [2:0] STEP_INTEG = 3'd6;
  localparam logic [2:0] STEP_DRIVE = 3'd7;

  typedef logic signed [71:0] wide_t;

  localparam wide_t S32_MAX = wide_t'(64'sd2147483647);
  localparam wide_t S32_MIN = wide_t'(-64'sd2147483648);

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       step_en;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic op_reset;
  } status_t;

  function automatic logic signed [31:0] sat32(input wide_t x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (x < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_sym(input wide_t x,
                                                   input logic [LIMIT_W-1:0] lim);
    wide_t hi;
    logic signed [31:0] r;
    hi = wide_t'({1'b0, lim});
    if (x > hi) begin
      r = hi[31:0];
    end else if (x < -hi) begin
      r = 32'(-hi);
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/pfd_ctrl.sv */
// sequencer for the pid step: accept, eight multiply steps or a state clear, result hand-off
`timescale 1ns / 1ps
`default_nettype none

module pfd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire pfd_pkg::status_t status,
  output pfd_pkg::cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_RST  = 2'd2;

  logic [1:0] state, state_next;
  logic [2:0] step, step_next;
  logic       out_set;
  logic       slot_free;

  // output register can take a new beat this cycle
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    step_next   = step;
    out_set     = 1'b0;
    cmd         = '0;
    cmd.step    = step;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
          step_next  = pfd_pkg::STEP_ERR;
        end
      end
      ST_RUN: begin
        if (step == pfd_pkg::STEP_ERR && status.op_reset) begin
          state_next = ST_RST;
        end else if (step == pfd_pkg::STEP_DRIVE) begin
          if (slot_free) begin
            cmd.step_en = 1'b1;
            out_set     = 1'b1;
            state_next  = ST_IDLE;
          end
        end else begin
          cmd.step_en = 1'b1;
          step_next   = step + 3'd1;
        end
      end
      ST_RST: begin
        if (slot_free) begin
          cmd.clear  = 1'b1;
          out_set    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= pfd_pkg::STEP_ERR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/pfd_dp.sv */
// datapath: input latch, error unwrap, shared multiplier, filter/integral state, result register
`timescale 1ns / 1ps
`default_nettype none

module pfd_dp #(
  parameter int FRAC_BITS = pfd_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pfd_pkg::cmd_t               cmd,
  output pfd_pkg::status_t                 status,
  input  wire logic                        operation,
  input  wire logic signed [31:0]          set_point,
  input  wire logic signed [31:0]          measured,
  input  wire logic [pfd_pkg::DT_BITS-1:0] time_step,
  input  wire logic                        integrate_enable,
  input  wire logic [pfd_pkg::GAIN_W-1:0]  prop_gain,
  input  wire logic [pfd_pkg::GAIN_W-1:0]  integ_gain,
  input  wire logic [pfd_pkg::GAIN_W-1:0]  deriv_gain,
  input  wire logic [pfd_pkg::GAIN_W-1:0]  filter_coeff,
  input  wire logic [pfd_pkg::LIMIT_W-1:0] integral_limit,
  input  wire logic [pfd_pkg::LIMIT_W-1:0] output_limit,
  input  wire logic                        wrap_enable,
  output logic signed [31:0]               drive
);

  localparam pfd_pkg::wide_t HALF_TURN = pfd_pkg::wide_t'(180) <<< FRAC_BITS;
  localparam pfd_pkg::wide_t FULL_TURN = pfd_pkg::wide_t'(360) <<< FRAC_BITS;

  // latched beat
  logic                        op_r;
  logic signed [31:0]          set_r;
  logic signed [31:0]          meas_r;
  logic [pfd_pkg::DT_BITS-1:0] dt_r;
  logic                        ie_r;

  // controller state
  logic signed [31:0] integral_sum;
  logic signed [31:0] last_error;
  logic signed [31:0] last_deriv;

  // per-step intermediates
  logic signed [31:0]               err_r;
  logic [pfd_pkg::GAIN_W-1:0]       fcdt_r;
  logic [pfd_pkg::GAIN_W-1:0]       kidt_r;
  logic [pfd_pkg::LIMIT_W-1:0]      kdfc_r;
  pfd_pkg::wide_t                   acc_d_r;
  logic signed [31:0]               d_r;
  logic signed [pfd_pkg::PROD_W-1:0] prod_r;

  logic signed [31:0]                mul_a;
  logic signed [32:0]                mul_b;
  logic signed [pfd_pkg::PROD_W-1:0] prod_sh;
  pfd_pkg::wide_t                    prod_w;
  pfd_pkg::wide_t                    err_raw;
  pfd_pkg::wide_t                    diff;
  pfd_pkg::wide_t                    err_wrap;
  pfd_pkg::wide_t                    isum_add;
  logic signed [31:0]                isum_sat;

  assign status.op_reset = op_r;

  assign prod_sh = prod_r >>> FRAC_BITS;
  assign prod_w  = pfd_pkg::wide_t'(prod_sh);

  // error with optional heading unwrap
  always_comb begin
    err_raw  = pfd_pkg::wide_t'(set_r) - pfd_pkg::wide_t'(meas_r);
    diff     = pfd_pkg::wide_t'(last_error) - err_raw;
    err_wrap = err_raw;
    if (wrap_enable) begin
      priority if (diff > HALF_TURN) begin
        err_wrap = err_raw + FULL_TURN;
      end else if (diff < -HALF_TURN) begin
        err_wrap = err_raw - FULL_TURN;
      end else begin
        err_wrap = err_raw;
      end
    end
  end

  always_comb begin
    isum_add = pfd_pkg::wide_t'(integral_sum) + prod_w;
    isum_sat = ie_r ? pfd_pkg::sat32(isum_add) : integral_sum;
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.step)
      pfd_pkg::STEP_ERR: begin
        mul_a = {8'd0, filter_coeff};
        mul_b = {9'd0, dt_r};
      end
      pfd_pkg::STEP_FCDT: begin
        mul_a = {8'd0, deriv_gain};
        mul_b = {9'd0, filter_coeff};
      end
      pfd_pkg::STEP_KDFC: begin
        mul_a = {8'd0, integ_gain};
        mul_b = {9'd0, dt_r};
      end
      pfd_pkg::STEP_KIDT: begin
        mul_a = {8'd0, fcdt_r};
        mul_b = {last_deriv[31], last_deriv};
      end
      pfd_pkg::STEP_DFILT: begin
        mul_a = {1'b0, kdfc_r};
        mul_b = {err_r[31], err_r} - {last_error[31], last_error};
      end
      pfd_pkg::STEP_DERIV: begin
        mul_a = {8'd0, kidt_r};
        mul_b = {err_r[31], err_r};
      end
      pfd_pkg::STEP_INTEG: begin
        mul_a = {8'd0, prop_gain};
        mul_b = {err_r[31], err_r};
      end
      pfd_pkg::STEP_DRIVE: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      last_error   <= '0;
      last_deriv   <= '0;
      op_r         <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r   <= operation;
        set_r  <= set_point;
        meas_r <= measured;
        dt_r   <= time_step;
        ie_r   <= integrate_enable;
      end
      if (cmd.step_en) begin
        prod_r <= pfd_pkg::PROD_W'(mul_a) * pfd_pkg::PROD_W'(mul_b);
        unique case (cmd.step)
          pfd_pkg::STEP_ERR: begin
            err_r <= pfd_pkg::sat32(err_wrap);
          end
          pfd_pkg::STEP_FCDT: begin
            fcdt_r <= prod_r[pfd_pkg::DT_BITS +: pfd_pkg::GAIN_W];
          end
          pfd_pkg::STEP_KDFC: begin
            if (prod_w > pfd_pkg::S32_MAX) begin
              kdfc_r <= {pfd_pkg::LIMIT_W{1'b1}};
            end else begin
              kdfc_r <= prod_sh[pfd_pkg::LIMIT_W-1:0];
            end
          end
          pfd_pkg::STEP_KIDT: begin
            kidt_r <= prod_r[pfd_pkg::DT_BITS +: pfd_pkg::GAIN_W];
          end
          pfd_pkg::STEP_DFILT: begin
            acc_d_r <= pfd_pkg::wide_t'(last_deriv) - prod_w;
          end
          pfd_pkg::STEP_DERIV: begin
            d_r <= pfd_pkg::sat32(acc_d_r + prod_w);
          end
          pfd_pkg::STEP_INTEG: begin
            integral_sum <= pfd_pkg::clamp_sym(pfd_pkg::wide_t'(isum_sat), integral_limit);
          end
          pfd_pkg::STEP_DRIVE: begin
            drive      <= pfd_pkg::clamp_sym(prod_w + pfd_pkg::wide_t'(integral_sum)
                                             + pfd_pkg::wide_t'(d_r), output_limit);
            last_error <= err_r;
            last_deriv <= d_r;
          end
        endcase
      end
      if (cmd.clear) begin
        integral_sum <= '0;
        last_error   <= '0;
        last_deriv   <= '0;
        drive        <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/pid_filtered_derivative_wrap.sv */
// top level: config registers, step sequencer and pid datapath
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------------------
// in        | in_valid/in_stall  | operation, set_point, measured, time_step,
//           |                    | integrate_enable
// out       | out_valid/out_stall| drive
// config    | apb psel/penable   | paddr[4:0], pwdata/prdata 32 bits, pready tied high
//
// a control step is an accept and then eight steps on the shared 32x33 multiplier; the input
// stalls until the last step has handed off its result
// a reset operation skips the multiply steps, clears the controller state and answers drive = 0
// rst (synchronous) clears the sequencer, the output beat and the controller state
// a stalled result holds the last step; a new beat is taken while a result waits

module pid_filtered_derivative_wrap #(
  parameter int FRAC_BITS = pfd_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input beat
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         operation,
  input  wire logic signed [31:0]           set_point,
  input  wire logic signed [31:0]           measured,
  input  wire logic [pfd_pkg::DT_BITS-1:0]  time_step,
  input  wire logic                         integrate_enable,
  // result beat
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [31:0]                drive,
  // config port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pfd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pfd_pkg::DATA_W-1:0]   pwdata,
  output logic [pfd_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  logic [pfd_pkg::GAIN_W-1:0]  prop_gain;
  logic [pfd_pkg::GAIN_W-1:0]  integ_gain;
  logic [pfd_pkg::GAIN_W-1:0]  deriv_gain;
  logic [pfd_pkg::GAIN_W-1:0]  filter_coeff;
  logic [pfd_pkg::LIMIT_W-1:0] integral_limit;
  logic [pfd_pkg::LIMIT_W-1:0] output_limit;
  logic                        wrap_enable;

  logic [2:0]       reg_idx;
  logic             cfg_wr;
  pfd_pkg::cmd_t    cmd;
  pfd_pkg::status_t status;

  assign pready  = 1'b1;
  // registers sit on word addresses, byte offset bits are ignored
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= '0;
      integ_gain     <= '0;
      deriv_gain     <= '0;
      filter_coeff   <= '0;
      integral_limit <= '0;
      output_limit   <= '0;
      wrap_enable    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pfd_pkg::REG_PROP_GAIN:      prop_gain      <= pwdata[pfd_pkg::GAIN_W-1:0];
        pfd_pkg::REG_INTEG_GAIN:     integ_gain     <= pwdata[pfd_pkg::GAIN_W-1:0];
        pfd_pkg::REG_DERIV_GAIN:     deriv_gain     <= pwdata[pfd_pkg::GAIN_W-1:0];
        pfd_pkg::REG_FILTER_COEFF:   filter_coeff   <= pwdata[pfd_pkg::GAIN_W-1:0];
        pfd_pkg::REG_INTEGRAL_LIMIT: integral_limit <= pwdata[pfd_pkg::LIMIT_W-1:0];
        pfd_pkg::REG_OUTPUT_LIMIT:   output_limit   <= pwdata[pfd_pkg::LIMIT_W-1:0];
        pfd_pkg::REG_WRAP_ENABLE:    wrap_enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read-back, unmapped addresses read as zero
  always_comb begin
    unique case (reg_idx)
      pfd_pkg::REG_PROP_GAIN:      prdata = {8'd0, prop_gain};
      pfd_pkg::REG_INTEG_GAIN:     prdata = {8'd0, integ_gain};
      pfd_pkg::REG_DERIV_GAIN:     prdata = {8'd0, deriv_gain};
      pfd_pkg::REG_FILTER_COEFF:   prdata = {8'd0, filter_coeff};
      pfd_pkg::REG_INTEGRAL_LIMIT: prdata = {1'b0, integral_limit};
      pfd_pkg::REG_OUTPUT_LIMIT:   prdata = {1'b0, output_limit};
      pfd_pkg::REG_WRAP_ENABLE:    prdata = {31'd0, wrap_enable};
      default:                     prdata = '0;
    endcase
  end

  // sequencer: accept, step through the multiply schedule, hand off the result beat
  pfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and controller state; drive is the output register
  pfd_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .operation        (operation),
    .set_point        (set_point),
    .measured         (measured),
    .time_step        (time_step),
    .integrate_enable (integrate_enable),
    .prop_gain        (prop_gain),
    .integ_gain       (integ_gain),
    .deriv_gain       (deriv_gain),
    .filter_coeff     (filter_coeff),
    .integral_limit   (integral_limit),
    .output_limit     (output_limit),
    .wrap_enable      (wrap_enable),
    .drive            (drive)
  );

endmodule

`default_nettype wire

/* tb/sv/pid_drive_monitor.sv */
// drive monitor: watches the step, drive and register ports, predicts each drive beat and compares
`timescale 1ns / 1ps

package pfd_tb_pkg;
  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_RESET = 1'b1
  } op_t;
endpackage

module pid_drive_monitor
  import pfd_pkg::*;
  import pfd_tb_pkg::*;
#(
  parameter int FRAC = FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                operation,
  input  logic signed [31:0]  set_point,
  input  logic signed [31:0]  measured,
  input  logic [DT_BITS-1:0]  time_step,
  input  logic                integrate_enable,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [31:0]  drive,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output int                  fail_count,
  output int                  pending
);

  typedef logic signed [127:0] big_t;

  localparam big_t HALF_TURN = big_t'(180) <<< FRAC;
  localparam big_t FULL_TURN = big_t'(360) <<< FRAC;
  localparam big_t WORD_MAX  = (big_t'(1) <<< 31) - 1;
  localparam big_t WORD_MIN  = -(big_t'(1) <<< 31);

  // register copies
  logic [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg, fc_reg;
  logic [LIMIT_W-1:0] ilim_reg, olim_reg;
  logic               wrap_reg;

  // controller state
  logic signed [31:0] integ_acc, prev_err, prev_deriv;

  logic signed [31:0] drive_due[$];
  logic signed [31:0] want;

  function automatic logic signed [31:0] saturate_word(input big_t x);
    big_t r;
    r = (x > WORD_MAX) ? WORD_MAX : ((x < WORD_MIN) ? WORD_MIN : x);
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] limit_sym(input big_t x, input logic [LIMIT_W-1:0] lim);
    big_t hi, lo, r;
    hi = big_t'(lim);
    lo = -hi;
    r = (x > hi) ? hi : ((x < lo) ? lo : x);
    return r[31:0];
  endfunction

  // one control step; updates the controller state and returns the drive
  function automatic logic signed [31:0] control_step(input logic signed [31:0] sp,
                                                      input logic signed [31:0] meas,
                                                      input logic [DT_BITS-1:0] dt,
                                                      input logic ien);
    big_t err, d, drv, fcdt, kdfc, kidt;
    logic [63:0] prod_u;
    err = big_t'(sp) - big_t'(meas);
    if (wrap_reg) begin
      if (big_t'(prev_err) - err > HALF_TURN) begin
        err = err + FULL_TURN;
      end else if (big_t'(prev_err) - err < -HALF_TURN) begin
        err = err - FULL_TURN;
      end
    end
    err = big_t'(saturate_word(err));

    // filtered derivative
    prod_u = 64'(fc_reg) * 64'(dt);
    fcdt = big_t'(prod_u >> DT_BITS);
    prod_u = 64'(kd_reg) * 64'(fc_reg);
    kdfc = big_t'(prod_u >> FRAC);
    if (kdfc > WORD_MAX) begin
      kdfc = WORD_MAX;
    end
    d = big_t'(prev_deriv) - ((fcdt * big_t'(prev_deriv)) >>> FRAC)
        + ((kdfc * (err - big_t'(prev_err))) >>> FRAC);
    d = big_t'(saturate_word(d));

    // integral, clamped every step
    if (ien) begin
      prod_u = 64'(ki_reg) * 64'(dt);
      kidt = big_t'(prod_u >> DT_BITS);
      integ_acc = saturate_word(big_t'(integ_acc) + ((kidt * err) >>> FRAC));
    end
    integ_acc = limit_sym(big_t'(integ_acc), ilim_reg);

    drv = ((big_t'(kp_reg) * err) >>> FRAC) + big_t'(integ_acc) + d;
    prev_err = err[31:0];
    prev_deriv = d[31:0];
    return limit_sym(drv, olim_reg);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kp_reg = '0;
      ki_reg = '0;
      kd_reg = '0;
      fc_reg = '0;
      ilim_reg = '0;
      olim_reg = '0;
      wrap_reg = 1'b0;
      integ_acc = '0;
      prev_err = '0;
      prev_deriv = '0;
      drive_due.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_PROP_GAIN:      kp_reg = pwdata[GAIN_W-1:0];
          REG_INTEG_GAIN:     ki_reg = pwdata[GAIN_W-1:0];
          REG_DERIV_GAIN:     kd_reg = pwdata[GAIN_W-1:0];
          REG_FILTER_COEFF:   fc_reg = pwdata[GAIN_W-1:0];
          REG_INTEGRAL_LIMIT: ilim_reg = pwdata[LIMIT_W-1:0];
          REG_OUTPUT_LIMIT:   olim_reg = pwdata[LIMIT_W-1:0];
          REG_WRAP_ENABLE:    wrap_reg = pwdata[0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (drive_due.size() == 0) begin
          $error("drive beat with no step waiting: actual %0d", drive);
          fail_count++;
        end else begin
          want = drive_due.pop_front();
          if (drive !== want) begin
            $error("drive mismatch: expected %0d actual %0d", want, drive);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (operation == OP_RESET) begin
          integ_acc = '0;
          prev_err = '0;
          prev_deriv = '0;
          drive_due.push_back('0);
        end else begin
          drive_due.push_back(control_step(set_point, measured, time_step, integrate_enable));
        end
      end

      pending <= drive_due.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// testbench top: clock, reset, step and register stimulus, drive monitor and verdict
`timescale 1ns / 1ps

module tb_top;
  import pfd_pkg::*;
  import pfd_tb_pkg::*;

  // 180 degrees in Q16.16, the unwrap threshold
  localparam int TURN_HALF      = 180 << FRAC_BITS_DEFAULT;
  // a few hundred degrees either way so the unwrap fires often
  localparam int ANGLE_SPAN     = 200 << FRAC_BITS_DEFAULT;
  localparam int MODERATE_SPAN  = 1 << 24;
  // margin after the last drive before touching registers
  localparam int SETTLE_CYCLES  = 16;
  // cycles with no beat on either channel before we give up
  localparam int QUIET_LIMIT    = 4000;
  localparam int RANDOM_PHASES  = 8;
  localparam int BEATS_PER_PHASE = 50;

  logic                 clk;
  logic                 rst;

  // step channel
  logic                 in_valid;
  logic                 in_stall;
  logic                 operation;
  logic signed [31:0]   set_point;
  logic signed [31:0]   measured;
  logic [DT_BITS-1:0]   time_step;
  logic                 integrate_enable;

  // drive channel
  logic                 out_valid;
  logic                 out_stall;
  logic signed [31:0]   drive;

  // register port
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  int                   gap_pct;
  int                   stall_pct;
  int                   fail_count;
  int                   pending;
  int                   quiet = 0;

  pid_filtered_derivative_wrap dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .set_point        (set_point),
    .measured         (measured),
    .time_step        (time_step),
    .integrate_enable (integrate_enable),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive            (drive),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  pid_drive_monitor drive_mon (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .set_point        (set_point),
    .measured         (measured),
    .time_step        (time_step),
    .integrate_enable (integrate_enable),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive            (drive),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // watchdog: any beat on either channel clears the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // idling mix per phase: none, sender gaps, receiver stalls, both
  task automatic set_mode(input int mode);
    case (mode)
      1: begin
        gap_pct = 63;
        stall_pct = 0;
      end
      2: begin
        gap_pct = 0;
        stall_pct = 63;
      end
      3: begin
        gap_pct = 36;
        stall_pct = 36;
      end
      default: begin
        gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  // setup cycle then access cycle; the write lands on the access edge
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_regs(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] fc,
                              input logic [LIMIT_W-1:0] ilim, input logic [LIMIT_W-1:0] olim,
                              input logic wrap);
    write_reg(REG_PROP_GAIN, DATA_W'(kp));
    write_reg(REG_INTEG_GAIN, DATA_W'(ki));
    write_reg(REG_DERIV_GAIN, DATA_W'(kd));
    write_reg(REG_FILTER_COEFF, DATA_W'(fc));
    write_reg(REG_INTEGRAL_LIMIT, DATA_W'(ilim));
    write_reg(REG_OUTPUT_LIMIT, DATA_W'(olim));
    write_reg(REG_WRAP_ENABLE, DATA_W'(wrap));
  endtask

  // drop valid, let every expected drive come back, then let the datapath settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one step beat; payload only moves after the previous beat was taken
  task automatic send_beat(input logic op, input logic signed [31:0] sp,
                           input logic signed [31:0] meas, input logic [DT_BITS-1:0] dt,
                           input logic ien);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    set_point <= sp;
    measured <= meas;
    time_step <= dt;
    integrate_enable <= ien;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom_range(0, 24'h040000));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return LIMIT_W'($urandom_range(1, 32'h0100_0000));
      default: return LIMIT_W'($urandom);
    endcase
  endfunction

  // register set per random phase: a sane loop, the maxima, zero limits, then anything
  task automatic phase_regs(input int phase);
    case (phase)
      0: program_regs(24'h018000, 24'h008000, 24'h001000, 24'h0a0000,
                      31'h0064_0000, 31'h00c8_0000, 1'b1);
      1: program_regs('1, '1, '1, '1, '1, '1, 1'b0);
      2: program_regs(rand_gain(), rand_gain(), rand_gain(), rand_gain(), '0, '0, 1'b1);
      default: program_regs(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                            rand_limit(), rand_limit(), 1'($urandom_range(1)));
    endcase
  endtask

  // mostly heading-like errors so wrap and the filter see real sequences,
  // plus moderate values, full-range noise and the odd state clear
  task automatic random_beat;
    int                 pick;
    logic signed [31:0] sp;
    logic signed [31:0] meas;
    logic [DT_BITS-1:0] dt;
    logic               ien;
    pick = $urandom_range(99);
    dt = ($urandom_range(3) == 0) ? DT_BITS'($urandom) : DT_BITS'($urandom_range(1, 24'h00ffff));
    ien = ($urandom_range(3) != 0);
    if (pick < 60) begin
      sp = int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN;
      meas = int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN;
    end else if (pick < 85) begin
      sp = int'($urandom_range(0, 2 * MODERATE_SPAN)) - MODERATE_SPAN;
      meas = int'($urandom_range(0, 2 * MODERATE_SPAN)) - MODERATE_SPAN;
    end else begin
      sp = $urandom;
      meas = $urandom;
    end
    if (pick >= 95) begin
      send_beat(OP_RESET, sp, meas, dt, ien);
    end else begin
      send_beat(OP_STEP, sp, meas, dt, ien);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_STEP;
    set_point = '0;
    measured = '0;
    time_step = '0;
    integrate_enable = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset: zero limits pin drive to 0, even on a saturated error
    send_beat(OP_STEP, 32'sh7fffffff, 32'sh80000000, '1, 1'b1);
    send_beat(OP_RESET, 32'sh1234_5678, -32'sd99, 24'h00_8000, 1'b1);
    drain;

    // all maxima: error, integral and derivative saturation, kd*fc clipped
    program_regs('1, '1, '1, '1, '1, '1, 1'b0);
    send_beat(OP_STEP, 32'sh7fffffff, 32'sh80000000, '1, 1'b1);
    send_beat(OP_STEP, 32'sh80000000, 32'sh7fffffff, '1, 1'b1);
    send_beat(OP_STEP, '0, '0, '0, 1'b1);
    send_beat(OP_STEP, 32'sd12345, -32'sd777, '0, 1'b0);
    send_beat(OP_RESET, $urandom, $urandom, DT_BITS'($urandom), 1'b1);
    drain;

    // heading mode, thresholds from a cleared state: exactly 180 holds, one lsb past shifts
    program_regs(24'h010000, 24'h008000, 24'h002000, 24'h100000,
                 31'h0064_0000, 31'h00c8_0000, 1'b1);
    send_beat(OP_RESET, '0, '0, '0, 1'b0);
    send_beat(OP_STEP, -TURN_HALF, '0, 24'h010000, 1'b1);
    send_beat(OP_RESET, '0, '0, '0, 1'b0);
    send_beat(OP_STEP, -TURN_HALF - 1, '0, 24'h010000, 1'b1);
    send_beat(OP_RESET, '0, '0, '0, 1'b0);
    send_beat(OP_STEP, TURN_HALF, '0, 24'h010000, 1'b1);
    send_beat(OP_RESET, '0, '0, '0, 1'b0);
    send_beat(OP_STEP, TURN_HALF + 1, '0, 24'h010000, 1'b1);
    // huge error after the shift still saturates both ways
    send_beat(OP_STEP, 32'sh7fffffff, 32'sh80000000, 24'h010000, 1'b1);
    send_beat(OP_STEP, 32'sh80000000, 32'sh7fffffff, 24'h010000, 1'b1);
    // integration off still clamps the integral
    send_beat(OP_STEP, 32'sd65536, -32'sd65536, '1, 1'b0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain;
      phase_regs(phase);
      set_mode(phase % 4);
      repeat (BEATS_PER_PHASE) random_beat();
    end
    drain;

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
